>>> hw/rtl/u8dec_pkg.sv
// Shared types and constants for the UTF-8 validating decoder.
// Holds the command record passed from the front end to the back end.
// No dependencies.
`default_nettype none
package u8dec_pkg;

   localparam int CpWidth    = 21;
   localparam int LenWidth   = 3;
   localparam int QueueDepth = 4;
   localparam int QueueAw    = $clog2(QueueDepth);
   localparam int QueueCw    = $clog2(QueueDepth + 1);

   localparam logic [CpWidth-1:0] ReplResetCode = 21'h00FFFD;
   localparam logic [CpWidth-1:0] SurrogateLow  = 21'h00D800;
   localparam logic [CpWidth-1:0] SurrogateHigh = 21'h00DFFF;
   localparam logic [CpWidth-1:0] MaxCodePoint  = 21'h10FFFF;
   localparam logic [CpWidth-1:0] MinTwoByte    = 21'h000080;
   localparam logic [CpWidth-1:0] MinThreeByte  = 21'h000800;
   localparam logic [CpWidth-1:0] MinFourByte   = 21'h010000;

   typedef enum logic [1:0] {
      TAIL_NONE = 2'd0,
      TAIL_CP   = 2'd1,
      TAIL_EOT  = 2'd2
   } tail_type;

   // rep_cnt replacements first, then the tail result
   typedef struct packed {
      logic [LenWidth-1:0] rep_cnt;
      tail_type            tail;
      logic [CpWidth-1:0]  code_point;
   } cmd_type;

endpackage
`default_nettype wire

>>> hw/rtl/utf8_validating_decoder.sv
// Top level of the UTF-8 validating decoder: front end, command queue,
// back end and the replacement code register. Depends on u8dec_pkg.
//
//   Channel   Ports                          Moves
//   req       req_push/req_full              one text byte per transfer
//   rsp       rsp_empty/rsp_pop              one code point per transfer
//   csr       csr_we/csr_wdata               replacement code, write only
//
// One byte is taken per cycle while the four-entry command queue has room.
// The back end gives one result per cycle while results are popped; a byte causing n results
// keeps it busy until all n are given (up to four for a rejected four-byte sequence).
// The first result of a byte passes the command queue and the output register before the ports.
// Synchronous reset clears the pending sequence, the queue and the output valid flag.
`default_nettype none
module utf8_validating_decoder (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   input  wire logic [7:0]                    req_text_byte,
   output logic                               req_full,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [u8dec_pkg::CpWidth-1:0]      rsp_code_point,
   output logic                               rsp_error_flag,
   output logic                               rsp_end_of_text,
   output logic                               rsp_last,
   input  wire logic                          csr_we,
   input  wire logic [u8dec_pkg::CpWidth-1:0] csr_wdata
);

   logic [u8dec_pkg::CpWidth-1:0] repl_ff;
   logic                          accept;
   u8dec_pkg::cmd_type            front_cmd;
   logic                          front_cmd_valid;
   logic                          q_full;
   logic                          q_head_valid;
   u8dec_pkg::cmd_type            q_head;
   logic                          q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         repl_ff <= u8dec_pkg::ReplResetCode;
      end else if (csr_we) begin
         repl_ff <= csr_wdata;
      end
   end

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   u8dec_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .text_byte (req_text_byte),
      .cmd       (front_cmd),
      .cmd_valid (front_cmd_valid)
   );

   u8dec_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept && front_cmd_valid),
      .push_cmd   (front_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head       (q_head)
   );

   u8dec_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_head_valid),
      .head            (q_head),
      .head_pop        (q_pop),
      .repl_code       (repl_ff),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_code_point  (rsp_code_point),
      .rsp_error_flag  (rsp_error_flag),
      .rsp_end_of_text (rsp_end_of_text),
      .rsp_last        (rsp_last)
   );

   a_eot_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_end_of_text) |-> (rsp_last && !rsp_error_flag
         && (rsp_code_point == '0)))
      else $error("terminator result is not a clean final result");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("reset did not empty the decoder");

   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head_valid)
      else $error("back end popped an empty command queue");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_code_point)
         && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule
`default_nettype wire

>>> hw/rtl/u8dec_front.sv
// Front end: tracks the pending sequence and classifies each text byte
// into at most one command. Depends on u8dec_pkg.
`default_nettype none
module u8dec_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [7:0]                    text_byte,
   output u8dec_pkg::cmd_type                 cmd,
   output logic                               cmd_valid
);

   logic [u8dec_pkg::LenWidth-1:0] seq_len_ff, seq_len_in;
   logic [u8dec_pkg::LenWidth-1:0] rcvd_ff, rcvd_in;
   logic [u8dec_pkg::CpWidth-1:0]  pv_ff, pv_in;

   logic                           pending;
   logic                           is_cont;
   logic [u8dec_pkg::CpWidth-1:0]  pv_shift;
   logic [u8dec_pkg::LenWidth-1:0] rcvd_inc;
   logic                           bad;

   always_comb begin
      pending  = (seq_len_ff != '0);
      is_cont  = (text_byte[7:6] == 2'b10);
      pv_shift = {pv_ff[u8dec_pkg::CpWidth-7:0], text_byte[5:0]};
      rcvd_inc = rcvd_ff + 3'd1;
      bad = ((seq_len_ff == 3'd2) && (pv_shift < u8dec_pkg::MinTwoByte))
         || ((seq_len_ff == 3'd3) && (pv_shift < u8dec_pkg::MinThreeByte))
         || ((seq_len_ff == 3'd4) && (pv_shift < u8dec_pkg::MinFourByte))
         || ((pv_shift >= u8dec_pkg::SurrogateLow)
             && (pv_shift <= u8dec_pkg::SurrogateHigh))
         || (pv_shift > u8dec_pkg::MaxCodePoint);

      seq_len_in     = seq_len_ff;
      rcvd_in        = rcvd_ff;
      pv_in          = pv_ff;
      cmd.rep_cnt    = '0;
      cmd.tail       = u8dec_pkg::TAIL_NONE;
      cmd.code_point = '0;
      cmd_valid      = 1'b0;

      if (pending && is_cont) begin
         pv_in   = pv_shift;
         rcvd_in = rcvd_inc;
         if (rcvd_inc >= seq_len_ff) begin
            seq_len_in = '0;
            rcvd_in    = '0;
            pv_in      = '0;
            cmd_valid  = 1'b1;
            if (bad) begin
               cmd.rep_cnt = seq_len_ff;
            end else begin
               cmd.tail       = u8dec_pkg::TAIL_CP;
               cmd.code_point = pv_shift;
            end
         end
      end else begin
         // flush a broken sequence, then treat the byte as a new lead
         cmd.rep_cnt = {2'b00, pending};
         seq_len_in  = '0;
         rcvd_in     = '0;
         pv_in       = '0;
         if (text_byte == 8'h00) begin
            cmd.tail = u8dec_pkg::TAIL_EOT;
         end else if (!text_byte[7]) begin
            cmd.tail       = u8dec_pkg::TAIL_CP;
            cmd.code_point = {13'd0, text_byte};
         end else if (text_byte[7:5] == 3'b110) begin
            seq_len_in = 3'd2;
            rcvd_in    = 3'd1;
            pv_in      = {16'd0, text_byte[4:0]};
         end else if (text_byte[7:4] == 4'b1110) begin
            seq_len_in = 3'd3;
            rcvd_in    = 3'd1;
            pv_in      = {17'd0, text_byte[3:0]};
         end else if (text_byte[7:3] == 5'b11110) begin
            seq_len_in = 3'd4;
            rcvd_in    = 3'd1;
            pv_in      = {18'd0, text_byte[2:0]};
         end else begin
            cmd.rep_cnt = cmd.rep_cnt + 3'd1;
         end
         cmd_valid = (cmd.rep_cnt != '0) || (cmd.tail != u8dec_pkg::TAIL_NONE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_len_ff <= '0;
         rcvd_ff    <= '0;
         pv_ff      <= '0;
      end else if (accept) begin
         seq_len_ff <= seq_len_in;
         rcvd_ff    <= rcvd_in;
         pv_ff      <= pv_in;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/u8dec_cmd_queue.sv
// Short command queue between the front end and the back end.
// Depends on u8dec_pkg.
`default_nettype none
module u8dec_cmd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire u8dec_pkg::cmd_type push_cmd,
   output logic                    full,
   input  wire logic               pop,
   output logic                    head_valid,
   output u8dec_pkg::cmd_type      head
);

   u8dec_pkg::cmd_type                   mem_ff [u8dec_pkg::QueueDepth];
   logic [u8dec_pkg::QueueAw-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [u8dec_pkg::QueueCw-1:0]        count_ff;
   logic                                 do_push, do_pop;

   assign full       = (count_ff == u8dec_pkg::QueueCw'(u8dec_pkg::QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/u8dec_back.sv
// Back end: expands each command into result items, one per cycle while the output
// register is empty or popped, and holds each item in an output register. Depends on u8dec_pkg.
`default_nettype none
module u8dec_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          head_valid,
   input  wire u8dec_pkg::cmd_type            head,
   output logic                               head_pop,
   input  wire logic [u8dec_pkg::CpWidth-1:0] repl_code,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [u8dec_pkg::CpWidth-1:0]      rsp_code_point,
   output logic                               rsp_error_flag,
   output logic                               rsp_end_of_text,
   output logic                               rsp_last
);

   logic                                 out_valid_ff;
   logic [u8dec_pkg::CpWidth-1:0]        cp_ff, cp_in;
   logic                                 err_ff, err_in;
   logic                                 eot_ff, eot_in;
   logic                                 last_ff, last_in;
   logic [1:0]                           step_ff;
   logic [u8dec_pkg::LenWidth-1:0]       total;
   logic                                 load;

   always_comb begin
      load  = head_valid && (!out_valid_ff || rsp_pop);
      total = head.rep_cnt + {2'b00, (head.tail != u8dec_pkg::TAIL_NONE)};
      last_in = ({1'b0, step_ff} == (total - 3'd1));
      cp_in  = repl_code;
      err_in = 1'b1;
      eot_in = 1'b0;
      if ({1'b0, step_ff} >= head.rep_cnt) begin
         err_in = 1'b0;
         case (head.tail)
            u8dec_pkg::TAIL_CP: begin
               cp_in = head.code_point;
            end
            u8dec_pkg::TAIL_EOT: begin
               cp_in  = '0;
               eot_in = 1'b1;
            end
            default: begin
               cp_in = repl_code;
            end
         endcase
      end
      head_pop = load && last_in;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cp_ff   <= cp_in;
         err_ff  <= err_in;
         eot_ff  <= eot_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         if (load) begin
            out_valid_ff <= 1'b1;
            step_ff      <= last_in ? 2'd0 : step_ff + 2'd1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_code_point  = cp_ff;
   assign rsp_error_flag  = err_ff;
   assign rsp_end_of_text = eot_ff;
   assign rsp_last        = last_ff;

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for utf8_validating_decoder: directed byte table, then
// random UTF-8 text under several replacement codes, all predicted in-bench.
// Depends on u8dec_pkg and the utf8_validating_decoder RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HoldCycles = 80;

   typedef struct packed {
      logic [u8dec_pkg::CpWidth-1:0] code_point;
      logic                          error_flag;
      logic                          end_of_text;
      logic                          last;
   } cp_result_type;

   typedef struct packed {
      logic [7:0]                    text;
      logic                          typed;
      logic [u8dec_pkg::CpWidth-1:0] cp;
      logic                          err;
      logic                          eot;
   } byte_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_push = 1'b0;
   logic [7:0]                    req_text_byte = 8'h00;
   logic                          req_full;
   logic                          rsp_empty;
   logic                          rsp_pop = 1'b0;
   logic [u8dec_pkg::CpWidth-1:0] rsp_code_point;
   logic                          rsp_error_flag;
   logic                          rsp_end_of_text;
   logic                          rsp_last;
   logic                          csr_we = 1'b0;
   logic [u8dec_pkg::CpWidth-1:0] csr_wdata = '0;

   // decoder model state
   logic [u8dec_pkg::LenWidth-1:0] seq_len = '0;
   logic [u8dec_pkg::LenWidth-1:0] seq_count = '0;
   logic [u8dec_pkg::CpWidth-1:0]  seq_value = '0;
   logic [u8dec_pkg::CpWidth-1:0]  repl_value = u8dec_pkg::ReplResetCode;

   cp_result_type cp_due [$];
   bit            gaps_on = 1'b1;
   int            hold_asks = 0;
   int            errors = 0;
   int            bytes_sent = 0;
   int            results_seen = 0;
   int            full_cycles = 0;
   int            repl_writes = 0;

   byte_row_type directed_rows [26] = '{
      '{8'h41, 1'b1, 21'h000041, 1'b0, 1'b0},
      '{8'h00, 1'b1, 21'h000000, 1'b0, 1'b1},
      '{8'h7F, 1'b1, 21'h00007F, 1'b0, 1'b0},
      '{8'h80, 1'b1, u8dec_pkg::ReplResetCode, 1'b1, 1'b0},
      '{8'hFF, 1'b1, u8dec_pkg::ReplResetCode, 1'b1, 1'b0},
      '{8'hF8, 1'b1, u8dec_pkg::ReplResetCode, 1'b1, 1'b0},
      '{8'hC2, 1'b0, '0, 1'b0, 1'b0},
      '{8'hA9, 1'b0, '0, 1'b0, 1'b0},
      '{8'hF4, 1'b0, '0, 1'b0, 1'b0},
      '{8'h8F, 1'b0, '0, 1'b0, 1'b0},
      '{8'hBF, 1'b0, '0, 1'b0, 1'b0},
      '{8'hBF, 1'b1, u8dec_pkg::MaxCodePoint, 1'b0, 1'b0},
      '{8'hC0, 1'b0, '0, 1'b0, 1'b0},
      '{8'h80, 1'b0, '0, 1'b0, 1'b0},
      '{8'hED, 1'b0, '0, 1'b0, 1'b0},
      '{8'hA0, 1'b0, '0, 1'b0, 1'b0},
      '{8'h80, 1'b0, '0, 1'b0, 1'b0},
      '{8'hF4, 1'b0, '0, 1'b0, 1'b0},
      '{8'h90, 1'b0, '0, 1'b0, 1'b0},
      '{8'h80, 1'b0, '0, 1'b0, 1'b0},
      '{8'h80, 1'b0, '0, 1'b0, 1'b0},
      '{8'hC3, 1'b0, '0, 1'b0, 1'b0},
      '{8'h41, 1'b0, '0, 1'b0, 1'b0},
      '{8'hE2, 1'b0, '0, 1'b0, 1'b0},
      '{8'h82, 1'b0, '0, 1'b0, 1'b0},
      '{8'h00, 1'b0, '0, 1'b0, 1'b0}
   };

   utf8_validating_decoder uut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_text_byte   (req_text_byte),
      .req_full        (req_full),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_code_point  (rsp_code_point),
      .rsp_error_flag  (rsp_error_flag),
      .rsp_end_of_text (rsp_end_of_text),
      .rsp_last        (rsp_last),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   always #10 clock = ~clock;

   task automatic decode_byte(input logic [7:0] text, output cp_result_type res [4],
                              output int n);
      logic [u8dec_pkg::CpWidth-1:0]  value;
      logic [u8dec_pkg::LenWidth-1:0] count;
      logic [u8dec_pkg::LenWidth-1:0] len;
      bit                             bad;
      n = 0;
      if (seq_len != 0 && text[7:6] == 2'b10) begin
         value = {seq_value[u8dec_pkg::CpWidth-7:0], text[5:0]};
         count = seq_count + 1'b1;
         if (count >= seq_len) begin
            len = seq_len;
            bad = (len == 2 && value < u8dec_pkg::MinTwoByte) ||
                  (len == 3 && value < u8dec_pkg::MinThreeByte) ||
                  (len == 4 && value < u8dec_pkg::MinFourByte) ||
                  (value >= u8dec_pkg::SurrogateLow && value <= u8dec_pkg::SurrogateHigh) ||
                  value > u8dec_pkg::MaxCodePoint;
            seq_len = '0;
            seq_count = '0;
            seq_value = '0;
            if (bad) begin
               for (int i = 0; i < len; i++) begin
                  res[n] = '{repl_value, 1'b1, 1'b0, 1'b0};
                  n++;
               end
            end else begin
               res[n] = '{value, 1'b0, 1'b0, 1'b0};
               n++;
            end
         end else begin
            seq_value = value;
            seq_count = count;
         end
      end else begin
         if (seq_len != 0) begin
            seq_len = '0;
            seq_count = '0;
            seq_value = '0;
            res[n] = '{repl_value, 1'b1, 1'b0, 1'b0};
            n++;
         end
         if (text == 8'h00) begin
            res[n] = '{'0, 1'b0, 1'b1, 1'b0};
            n++;
         end else if (text < 8'h80) begin
            res[n] = '{u8dec_pkg::CpWidth'(text), 1'b0, 1'b0, 1'b0};
            n++;
         end else if (text[7:5] == 3'b110) begin
            seq_len = 3'd2;
            seq_value = u8dec_pkg::CpWidth'(text[4:0]);
            seq_count = 3'd1;
         end else if (text[7:4] == 4'b1110) begin
            seq_len = 3'd3;
            seq_value = u8dec_pkg::CpWidth'(text[3:0]);
            seq_count = 3'd1;
         end else if (text[7:3] == 5'b11110) begin
            seq_len = 3'd4;
            seq_value = u8dec_pkg::CpWidth'(text[2:0]);
            seq_count = 3'd1;
         end else begin
            res[n] = '{repl_value, 1'b1, 1'b0, 1'b0};
            n++;
         end
      end
      if (n > 0)
         res[n-1].last = 1'b1;
   endtask

   task automatic send_byte(input logic [7:0] text, input bit typed = 1'b0,
                            input cp_result_type want = '0);
      cp_result_type got [4];
      int            n;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_push <= 1'b1;
      req_text_byte <= text;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      decode_byte(text, got, n);
      if (typed)
         cp_due.push_back(want);
      else
         for (int i = 0; i < n; i++)
            cp_due.push_back(got[i]);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_encoded(input logic [u8dec_pkg::CpWidth-1:0] cp, input int len,
                               input int count);
      logic [7:0] seq [4];
      case (len)
         2: begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
         end
         3: begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
         end
         default: begin
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int i = 0; i < count; i++)
         send_byte(seq[i]);
   endtask

   task automatic send_text_unit();
      int                            kind;
      int                            len;
      logic [u8dec_pkg::CpWidth-1:0] cp;
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
         send_byte(8'($urandom_range(1, 127)));
      end else if (kind < 75) begin
         if (kind < 50) begin
            len = 2;
            cp = u8dec_pkg::CpWidth'($urandom_range(21'h80, 21'h7FF));
         end else if (kind < 65) begin
            len = 3;
            cp = u8dec_pkg::CpWidth'($urandom_range(21'h800, 21'hFFFF));
            if (cp >= u8dec_pkg::SurrogateLow && cp <= u8dec_pkg::SurrogateHigh)
               cp = cp ^ 21'h004000;
         end else begin
            len = 4;
            cp = u8dec_pkg::CpWidth'($urandom_range(21'h10000, 21'h10FFFF));
         end
         send_encoded(cp, len, len);
      end else if (kind < 80) begin
         send_byte(8'h00);
      end else if (kind < 85) begin
         send_byte(8'($urandom_range(0, 255)));
      end else if (kind < 90) begin
         len = $urandom_range(2, 4);
         send_encoded(u8dec_pkg::CpWidth'($urandom), len, $urandom_range(1, len - 1));
      end else if (kind < 95) begin
         len = $urandom_range(2, 4);
         if (len == 2)
            cp = u8dec_pkg::CpWidth'($urandom_range(0, 21'h7F));
         else if (len == 3)
            cp = $urandom_range(0, 1)
                 ? u8dec_pkg::CpWidth'($urandom_range(0, 21'h7FF))
                 : u8dec_pkg::CpWidth'($urandom_range(21'hD800, 21'hDFFF));
         else
            cp = $urandom_range(0, 1)
                 ? u8dec_pkg::CpWidth'($urandom_range(0, 21'hFFFF))
                 : u8dec_pkg::CpWidth'($urandom_range(21'h110000, 21'h1FFFFF));
         send_encoded(cp, len, len);
      end else begin
         send_byte(8'($urandom_range(8'h80, 8'hBF)));
      end
   endtask

   // drain outstanding results before touching the register
   task automatic write_repl(input logic [u8dec_pkg::CpWidth-1:0] value);
      req_push <= 1'b0;
      while (cp_due.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      repl_value = value;
      repl_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_random_text(input int count);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < count)
         send_text_unit();
   endtask

   initial begin : receiver
      int stall;
      int holds_done;
      stall = 0;
      holds_done = 0;
      forever begin
         @(negedge clock);
         if (holds_done != hold_asks) begin
            rsp_pop <= 1'b0;
            holds_done++;
            repeat (HoldCycles - 1) @(negedge clock);
         end else if (stall > 0) begin
            rsp_pop <= 1'b0;
            stall--;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_pop <= 1'b0;
            stall = $urandom_range(0, 10);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_results
      cp_result_type want;
      if (!reset && req_push && req_full)
         full_cycles++;
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen++;
         if (cp_due.size() == 0) begin
            $display("%0t: unexpected result cp=%h err=%b eot=%b last=%b", $time,
                     rsp_code_point, rsp_error_flag, rsp_end_of_text, rsp_last);
            errors++;
         end else begin
            want = cp_due.pop_front();
            if (rsp_code_point !== want.code_point) begin
               $display("%0t: code_point expected %h actual %h", $time,
                        want.code_point, rsp_code_point);
               errors++;
            end
            if (rsp_error_flag !== want.error_flag) begin
               $display("%0t: error_flag expected %b actual %b", $time,
                        want.error_flag, rsp_error_flag);
               errors++;
            end
            if (rsp_end_of_text !== want.end_of_text) begin
               $display("%0t: end_of_text expected %b actual %b", $time,
                        want.end_of_text, rsp_end_of_text);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_byte(directed_rows[i].text, directed_rows[i].typed,
                   '{directed_rows[i].cp, directed_rows[i].err, directed_rows[i].eot, 1'b1});

      write_repl('0);
      hold_asks <= hold_asks + 1;
      send_random_text(110);

      write_repl(u8dec_pkg::MaxCodePoint);
      send_random_text(110);

      write_repl(u8dec_pkg::CpWidth'($urandom_range(0, 21'h10FFFF)));
      send_random_text(110);

      write_repl(u8dec_pkg::ReplResetCode);
      gaps_on <= 1'b0;
      send_random_text(80);

      req_push <= 1'b0;
      while (cp_due.size() != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);

      $display("Sent %0d text bytes, checked %0d code points, %0d replacement code writes.",
               bytes_sent, results_seen, repl_writes);
      $display("Input held off by a full queue for %0d cycles.", full_cycles);
      if (errors == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   initial begin
      #(10_000_000);
      $display("testbench NOT OK");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/u8dec_pkg.sv
hw/rtl/u8dec_front.sv
hw/rtl/u8dec_cmd_queue.sv
hw/rtl/u8dec_back.sv
hw/rtl/utf8_validating_decoder.sv
tb/testbench.sv
